// ===== design/cmdrt_pkg.sv =====
`default_nettype none

package cmdrt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  localparam int SEQ_W = 16;
  localparam int RETRY_W = 3;
  localparam int TIME_W = 32;
  localparam int BASE_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 1'b1;

  localparam logic [BASE_W-1:0] BASE_TIMEOUT_RST = 16'd500;
  localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = 3'd5;

  typedef enum logic [1:0] {
    REQ_SEND = 2'd0,
    REQ_ACK  = 2'd1,
    REQ_TICK = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    EV_ACCEPTED    = 3'd0,
    EV_FULL        = 3'd1,
    EV_ACK_OK      = 3'd2,
    EV_ACK_UNKNOWN = 3'd3,
    EV_RETX        = 3'd4,
    EV_GAVE_UP     = 3'd5,
    EV_TICK_DONE   = 3'd6
  } ev_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_RESOLVE,
    S_TICK_INC,
    S_TICK_CHK,
    S_TICK_UPD,
    S_TICK_DONE
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

  // one table entry as seen at the read port
  typedef struct packed {
    logic               valid;
    logic [SEQ_W-1:0]   seq;
    logic [RETRY_W-1:0] retries;
    logic [TIME_W-1:0]  deadline;
  } tbl_ent_t;

  // write request: valid bit always written, fields only when load is set
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic               valid;
    logic               load;
    logic [SEQ_W-1:0]   seq;
    logic [RETRY_W-1:0] retries;
    logic [TIME_W-1:0]  deadline;
  } tbl_wr_t;

endpackage

`default_nettype wire

// ===== design/command_retransmit_table.sv =====
`default_nettype none

// Channel  Handshake            Payload
// in       in_valid / in_stall  in_req_type, in_seq_number
// out      out_valid/out_stall  out_event_kind, out_event_seq, out_retry_number, out_last
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_wdata
//
// Send and ack: accept the request, search the TABLE_DEPTH table entries in order, then
// resolve and post the result.
// Tick: advance time, check each entry in turn through the shared adder, form the new
// deadline in an extra step for each retransmit, then post the done result.
// Reset clears valid bits, time and the two registers (500, 5); no clearing pass.
// A stalled output register holds the scan at the next result-producing step.

module command_retransmit_table
  import cmdrt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_req_type,
  input  logic [SEQ_W-1:0]     in_seq_number,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_event_kind,
  output logic [SEQ_W-1:0]     out_event_seq,
  output logic [RETRY_W-1:0]   out_retry_number,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BASE_W-1:0]    cfg_wdata
);

  logic [BASE_W-1:0]  base_timeout_r;
  logic [RETRY_W-1:0] max_retries_r;
  alu_req_t           alu_req;
  logic [TIME_W-1:0]  alu_y;
  logic [IDX_W-1:0]   rd_idx;
  tbl_ent_t           ent;
  tbl_wr_t            tbl_wr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_timeout_r <= BASE_TIMEOUT_RST;
      max_retries_r  <= MAX_RETRIES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASE_TIMEOUT: base_timeout_r <= cfg_wdata;
        CFG_MAX_RETRIES:  max_retries_r  <= cfg_wdata[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  cmdrt_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  cmdrt_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (rd_idx),
    .ent    (ent),
    .wr     (tbl_wr)
  );

  cmdrt_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_seq_number    (in_seq_number),
    .base_timeout     (base_timeout_r),
    .max_retries      (max_retries_r),
    .alu_req          (alu_req),
    .alu_y            (alu_y),
    .rd_idx           (rd_idx),
    .ent              (ent),
    .tbl_wr           (tbl_wr),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_event_seq    (out_event_seq),
    .out_retry_number (out_retry_number),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

// ===== design/cmdrt_alu.sv =====
`default_nettype none

module cmdrt_alu
  import cmdrt_pkg::*;
(
  input  alu_req_t          req,
  output logic [TIME_W-1:0] y
);

  always_comb begin
    unique case (req.op)
      ALU_ADD: y = req.a + req.b;
      ALU_SUB: y = req.a - req.b;
      default: y = req.a + req.b;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/cmdrt_table.sv =====
`default_nettype none

module cmdrt_table
  import cmdrt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_idx,
  output tbl_ent_t         ent,
  input  tbl_wr_t          wr
);

  logic [TABLE_DEPTH-1:0] valid_r;
  logic [SEQ_W-1:0]       seq_mem      [TABLE_DEPTH];
  logic [RETRY_W-1:0]     retries_mem  [TABLE_DEPTH];
  logic [TIME_W-1:0]      deadline_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.idx] <= wr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.load) begin
      seq_mem[wr.idx]      <= wr.seq;
      retries_mem[wr.idx]  <= wr.retries;
      deadline_mem[wr.idx] <= wr.deadline;
    end
  end

  assign ent.valid    = valid_r[rd_idx];
  assign ent.seq      = seq_mem[rd_idx];
  assign ent.retries  = retries_mem[rd_idx];
  assign ent.deadline = deadline_mem[rd_idx];

endmodule

`default_nettype wire

// ===== design/cmdrt_seq.sv =====
`default_nettype none

module cmdrt_seq
  import cmdrt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [SEQ_W-1:0]   in_seq_number,
  input  logic [BASE_W-1:0]  base_timeout,
  input  logic [RETRY_W-1:0] max_retries,
  output alu_req_t           alu_req,
  input  logic [TIME_W-1:0]  alu_y,
  output logic [IDX_W-1:0]   rd_idx,
  input  tbl_ent_t           ent,
  output tbl_wr_t            tbl_wr,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_event_kind,
  output logic [SEQ_W-1:0]   out_event_seq,
  output logic [RETRY_W-1:0] out_retry_number,
  output logic               out_last
);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [SEQ_W-1:0]   seq_r, seq_nxt;
  logic               is_send_r, is_send_nxt;
  logic               match_r, match_nxt;
  logic [IDX_W-1:0]   match_idx_r, match_idx_nxt;
  logic               free_r, free_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic [TIME_W-1:0]  time_now_r, time_now_nxt;

  logic               out_valid_r;
  ev_kind_t           out_kind_r;
  logic [SEQ_W-1:0]   out_seq_r;
  logic [RETRY_W-1:0] out_retry_r;
  logic               out_last_r;

  logic               out_free;
  logic               emit;
  ev_kind_t           ev_kind;
  logic [SEQ_W-1:0]   ev_seq;
  logic [RETRY_W-1:0] ev_retry;
  logic               ev_last;
  logic [RETRY_W-1:0] retry_inc;
  logic [TIME_W-1:0]  backoff;
  logic               expired;
  logic               last_entry;

  assign out_free   = !out_valid_r || !out_stall;
  assign retry_inc  = ent.retries + 3'd1;
  assign backoff    = {{(TIME_W-BASE_W){1'b0}}, base_timeout} << retry_inc;
  assign expired    = ent.valid && !alu_y[TIME_W-1];
  assign last_entry = (idx_r == LAST_IDX);
  assign rd_idx     = idx_r;
  assign in_stall   = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    seq_nxt       = seq_r;
    is_send_nxt   = is_send_r;
    match_nxt     = match_r;
    match_idx_nxt = match_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    time_now_nxt  = time_now_r;
    emit          = 1'b0;
    ev_kind       = EV_TICK_DONE;
    ev_seq        = '0;
    ev_retry      = '0;
    ev_last       = 1'b0;
    tbl_wr        = '0;
    alu_req.op    = ALU_ADD;
    alu_req.a     = time_now_r;
    alu_req.b     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt     = '0;
          seq_nxt     = in_seq_number;
          is_send_nxt = (in_req_type == REQ_SEND);
          match_nxt   = 1'b0;
          free_nxt    = 1'b0;
          unique case (req_t'(in_req_type))
            REQ_SEND, REQ_ACK: state_nxt = S_SEARCH;
            REQ_TICK:          state_nxt = S_TICK_INC;
            default:           state_nxt = S_IDLE;
          endcase
        end
      end

      S_SEARCH: begin
        if (ent.valid && ent.seq == seq_r && !match_r) begin
          match_nxt     = 1'b1;
          match_idx_nxt = idx_r;
        end
        // remember the lowest free slot
        if (!ent.valid && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = idx_r;
        end
        if (last_entry) begin
          state_nxt = S_RESOLVE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_RESOLVE: begin
        alu_req.b = {{(TIME_W-BASE_W){1'b0}}, base_timeout};
        if (out_free) begin
          emit      = 1'b1;
          ev_seq    = seq_r;
          ev_last   = 1'b1;
          state_nxt = S_IDLE;
          if (is_send_r) begin
            if (match_r || free_r) begin
              tbl_wr.en       = 1'b1;
              tbl_wr.idx      = match_r ? match_idx_r : free_idx_r;
              tbl_wr.valid    = 1'b1;
              tbl_wr.load     = 1'b1;
              tbl_wr.seq      = seq_r;
              tbl_wr.retries  = '0;
              tbl_wr.deadline = alu_y;
              ev_kind         = EV_ACCEPTED;
            end else begin
              ev_kind = EV_FULL;
            end
          end else begin
            if (match_r) begin
              tbl_wr.en    = 1'b1;
              tbl_wr.idx   = match_idx_r;
              tbl_wr.valid = 1'b0;
              ev_kind      = EV_ACK_OK;
            end else begin
              ev_kind = EV_ACK_UNKNOWN;
            end
          end
        end
      end

      S_TICK_INC: begin
        alu_req.b    = 32'd1;
        time_now_nxt = alu_y;
        idx_nxt      = '0;
        state_nxt    = S_TICK_CHK;
      end

      S_TICK_CHK: begin
        // wrap-safe expiry: sign of now minus deadline
        alu_req.op = ALU_SUB;
        alu_req.b  = ent.deadline;
        if (!expired) begin
          if (last_entry) begin
            state_nxt = S_TICK_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else if (ent.retries >= max_retries) begin
          if (out_free) begin
            emit         = 1'b1;
            ev_kind      = EV_GAVE_UP;
            ev_seq       = ent.seq;
            tbl_wr.en    = 1'b1;
            tbl_wr.idx   = idx_r;
            tbl_wr.valid = 1'b0;
            if (last_entry) begin
              state_nxt = S_TICK_DONE;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end else begin
          state_nxt = S_TICK_UPD;
        end
      end

      S_TICK_UPD: begin
        alu_req.b = backoff;
        if (out_free) begin
          emit            = 1'b1;
          ev_kind         = EV_RETX;
          ev_seq          = ent.seq;
          ev_retry        = retry_inc;
          tbl_wr.en       = 1'b1;
          tbl_wr.idx      = idx_r;
          tbl_wr.valid    = 1'b1;
          tbl_wr.load     = 1'b1;
          tbl_wr.seq      = ent.seq;
          tbl_wr.retries  = retry_inc;
          tbl_wr.deadline = alu_y;
          if (last_entry) begin
            state_nxt = S_TICK_DONE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_TICK_CHK;
          end
        end
      end

      S_TICK_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          ev_kind   = EV_TICK_DONE;
          ev_last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      is_send_r   <= 1'b0;
      match_r     <= 1'b0;
      free_r      <= 1'b0;
      time_now_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      is_send_r  <= is_send_nxt;
      match_r    <= match_nxt;
      free_r     <= free_nxt;
      time_now_r <= time_now_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    seq_r       <= seq_nxt;
    match_idx_r <= match_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    if (emit) begin
      out_kind_r  <= ev_kind;
      out_seq_r   <= ev_seq;
      out_retry_r <= ev_retry;
      out_last_r  <= ev_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_kind_r;
  assign out_event_seq    = out_seq_r;
  assign out_retry_number = out_retry_r;
  assign out_last         = out_last_r;

  a_tick_inc_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK_INC) |=> (time_now_r == $past(time_now_r) + 32'd1))
    else $error("time did not advance by one on tick");

  a_scan_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK_INC) |=> (state_r == S_TICK_CHK && idx_r == '0))
    else $error("tick scan did not start at entry zero");

  a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == EV_TICK_DONE) |-> (out_last_r && out_seq_r == '0))
    else $error("tick done result malformed");

  a_scan_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == EV_RETX || out_kind_r == EV_GAVE_UP)) |-> !out_last_r)
    else $error("scan result flagged as last");

  a_retx_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == EV_RETX) |-> (out_retry_r != '0))
    else $error("retransmit with zero retry count");

endmodule

`default_nettype wire
